@@ design/zfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfr_pkg: shared types and constants for the framed-byte receiver
// Command codes, event codes, header formats and the request type that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package zfr_pkg;

    localparam int PKT_BUF_SIZE = 1024;
    localparam int CANCEL_RUN   = 5;
    localparam int CNT_W        = $clog2(PKT_BUF_SIZE + 1);

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_ARM  = 2'd2;

    localparam logic [2:0] EV_HDR_OK  = 3'd0;
    localparam logic [2:0] EV_HDR_BAD = 3'd1;
    localparam logic [2:0] EV_PAYLOAD = 3'd2;
    localparam logic [2:0] EV_PKT_END = 3'd3;
    localparam logic [2:0] EV_CANCEL  = 3'd4;
    localparam logic [2:0] EV_OO      = 3'd5;
    localparam logic [2:0] EV_OVERFLW = 3'd6;

    localparam logic [1:0] FMT_HEX = 2'd0;
    localparam logic [1:0] FMT_B16 = 2'd1;
    localparam logic [1:0] FMT_B32 = 2'd2;

    localparam logic [7:0] CH_ZPAD = 8'h2a;
    localparam logic [7:0] CH_ZDLE = 8'h18;
    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;
    localparam logic [7:0] CH_O    = 8'h4f;

    // request from front to back: a link byte that survived filtering,
    // a cancel, or a data-mode entry
    typedef struct packed {
        logic       cancel;
        logic       data_mode;
        logic [7:0] byte_val;
    } t_req;

endpackage

@@ design/zfr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfr_front: command intake and link filter
// Drops XON/XOFF, counts CAN runs, turns commands into requests for the
// back part. Arming OO is folded into the next request stream via a flag.
// ----------------------------------------------------------------------------
module zfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_command,
    input  logic [7:0]    i_data_byte,
    output logic          o_req_valid,
    output logic          o_arm,
    output zfr_pkg::t_req o_req,
    input  logic          i_q_ready
);
    logic [2:0] r_cancel_run, n_cancel_run;
    logic       take;
    logic       is_can;

    assign o_ready = i_q_ready;
    assign take    = i_valid && o_ready;
    assign is_can  = (i_data_byte == zfr_pkg::CH_ZDLE);

    // cancel run counter, cleared on a non-CAN byte and when the run reaches CANCEL_RUN
    always_comb begin
        n_cancel_run = r_cancel_run;
        if (take && i_command == zfr_pkg::CMD_BYTE) begin
            if (is_can) begin
                n_cancel_run = (r_cancel_run < 3'd7) ? r_cancel_run + 3'd1 : r_cancel_run;
                if (n_cancel_run >= 3'(zfr_pkg::CANCEL_RUN)) n_cancel_run = 3'd0;
            end else begin
                n_cancel_run = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cancel_run <= 3'd0;
        end else begin
            r_cancel_run <= n_cancel_run;
        end
    end

    // classify
    always_comb begin
        o_req_valid    = 1'b0;
        o_arm          = 1'b0;
        o_req.cancel   = 1'b0;
        o_req.data_mode = 1'b0;
        o_req.byte_val = i_data_byte;
        if (take) begin
            case (i_command)
                zfr_pkg::CMD_DATA: begin
                    o_req_valid     = 1'b1;
                    o_req.data_mode = 1'b1;
                end
                zfr_pkg::CMD_ARM: begin
                    o_req_valid = 1'b1;
                    o_arm       = 1'b1;
                end
                zfr_pkg::CMD_BYTE: begin
                    if (is_can && r_cancel_run + 3'd1 >= 3'(zfr_pkg::CANCEL_RUN)) begin
                        o_req_valid  = 1'b1;
                        o_req.cancel = 1'b1;
                    end else if (i_data_byte != zfr_pkg::CH_XON &&
                                 i_data_byte != zfr_pkg::CH_XOFF) begin
                        o_req_valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

@@ design/zfr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfr_queue: two-entry request queue
// Decouples the front part from the back part; ready reflects free space.
// ----------------------------------------------------------------------------
module zfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_push_arm,
    input  zfr_pkg::t_req i_push_req,
    output logic          o_not_full,
    output logic          o_valid,
    output logic          o_arm,
    output zfr_pkg::t_req o_req,
    input  logic          i_pop
);
    logic          r_arm [2];
    zfr_pkg::t_req r_req [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_not_full = (r_cnt != 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_arm      = r_arm[r_rp];
    assign o_req      = r_req[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_arm[r_wp] <= i_push_arm;
            r_req[r_wp] <= i_push_req;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ design/zfr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zfr_back: header and packet parser
// Hunts for frame starts, decodes headers, streams payload, runs both CRCs
// and holds one result in an output register.
// ----------------------------------------------------------------------------
module zfr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_arm,
    input  zfr_pkg::t_req             i_req,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_event_kind,
    output logic [7:0]                o_frame_type,
    output logic [31:0]               o_frame_info,
    output logic [1:0]                o_header_format,
    output logic [7:0]                o_payload_value,
    output logic [1:0]                o_end_kind,
    output logic                      o_crc_good,
    output logic [10:0]               o_payload_count
);
    typedef enum logic [6:0] {
        PH_HUNT   = 7'b0000001,
        PH_GOTPAD = 7'b0000010,
        PH_GOTO   = 7'b0000100,
        PH_FORMAT = 7'b0001000,
        PH_HIGH   = 7'b0010000,
        PH_LOW    = 7'b0100000,
        PH_DATA   = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_esc, n_esc;
    logic        r_oo, n_oo;
    logic [1:0]  r_fmt, n_fmt;
    logic [3:0]  r_hpos, n_hpos;
    logic [7:0]  r_hb [5];
    logic [15:0] r_crc16, n_crc16;
    logic [31:0] r_crc32, n_crc32;
    logic [zfr_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]  r_trail, n_trail;
    logic [1:0]  r_term, n_term;
    logic [3:0]  r_nib, n_nib;

    logic        hb_we;
    logic [7:0]  hb_wd;

    logic        emit;
    logic [2:0]  ev;
    logic [7:0]  ev_pay;
    logic [1:0]  ev_end;
    logic        ev_crc;
    logic [10:0] ev_cnt;
    logic        ev_hdr;

    logic        feed;
    logic [7:0]  feed_b;
    logic        crc_restart;

    logic        r_ovalid;

    logic [7:0]  c, ch;
    logic [4:0]  hx;
    logic [2:0]  trail;
    logic [15:0] c16;
    logic [31:0] c32;
    logic [zfr_pkg::CNT_W-1:0] cnt_inc;

    // one request per cycle while the output slot is free or draining
    assign o_pop   = i_valid && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;

    function automatic logic [7:0] unesc(input logic [7:0] b);
        if (b == 8'h6c) return 8'h7f;
        if (b == 8'h6d) return 8'hff;
        return b ^ 8'h40;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hexv(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
        return 5'h10;
    endfunction

    // bytewise CRC update for both polynomials
    always_comb begin
        c16 = r_crc16 ^ {feed_b, 8'h00};
        c32 = r_crc32 ^ {24'h0, feed_b};
        for (int i = 0; i < 8; i++) begin
            c16 = c16[15] ? ((c16 << 1) ^ 16'h1021) : (c16 << 1);
            c32 = c32[0] ? ((c32 >> 1) ^ 32'hedb88320) : (c32 >> 1);
        end
    end

    // main parse step
    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_oo    = r_oo;
        n_fmt   = r_fmt;
        n_hpos  = r_hpos;
        n_cnt   = r_cnt;
        n_trail = r_trail;
        n_term  = r_term;
        n_nib   = r_nib;
        hb_we   = 1'b0;
        hb_wd   = 8'h00;
        emit    = 1'b0;
        ev      = zfr_pkg::EV_HDR_OK;
        ev_pay  = 8'h00;
        ev_end  = 2'd0;
        ev_crc  = 1'b0;
        ev_cnt  = 11'd0;
        ev_hdr  = 1'b0;
        feed    = 1'b0;
        feed_b  = 8'h00;
        crc_restart = 1'b0;
        c       = i_req.byte_val;
        ch      = c;
        hx      = 5'h10;
        trail   = (r_fmt == zfr_pkg::FMT_B32) ? 3'd5 : 3'd3;
        cnt_inc = r_cnt + 1'b1;
        if (o_pop) begin
            if (i_arm) begin
                n_oo = 1'b1;
            end else if (i_req.data_mode) begin
                n_phase = PH_DATA;
                n_esc   = 1'b0;
                n_cnt   = '0;
                n_trail = 3'd0;
                crc_restart = 1'b1;
            end else if (i_req.cancel) begin
                n_phase = PH_HUNT;
                n_esc   = 1'b0;
                emit    = 1'b1;
                ev      = zfr_pkg::EV_CANCEL;
            end else if (r_phase == PH_DATA) begin
                if (c == zfr_pkg::CH_ZDLE && !r_esc) begin
                    n_esc = 1'b1;
                end else if (r_cnt >= zfr_pkg::CNT_W'(zfr_pkg::PKT_BUF_SIZE)) begin
                    n_phase = PH_HUNT;
                    n_esc   = 1'b0;
                    n_cnt   = '0;
                    n_trail = 3'd0;
                    emit    = 1'b1;
                    ev      = zfr_pkg::EV_OVERFLW;
                end else begin
                    ch = c;
                    n_trail = r_trail;
                    if (r_esc) begin
                        if (c >= 8'h68 && c <= 8'h6b) begin
                            n_term  = 2'(c - 8'h68);
                            n_trail = trail;
                        end else begin
                            ch = unesc(c);
                        end
                        n_esc = 1'b0;
                    end
                    feed   = 1'b1;
                    feed_b = ch;
                    n_cnt  = cnt_inc;
                    if (n_trail == 3'd0) begin
                        emit   = 1'b1;
                        ev     = zfr_pkg::EV_PAYLOAD;
                        ev_pay = ch;
                    end else if (n_trail == 3'd1) begin
                        emit    = 1'b1;
                        ev      = zfr_pkg::EV_PKT_END;
                        ev_end  = n_term;
                        ev_crc  = (r_fmt == zfr_pkg::FMT_B32) ? (c32 == 32'hdebb20e3)
                                                              : (c16 == 16'h0000);
                        ev_cnt  = (cnt_inc >= zfr_pkg::CNT_W'(trail))
                                  ? 11'(cnt_inc - zfr_pkg::CNT_W'(trail)) : 11'd0;
                        n_phase = PH_HUNT;
                        n_cnt   = '0;
                        n_trail = 3'd0;
                    end else begin
                        n_trail = n_trail - 3'd1;
                    end
                end
            end else if (r_phase == PH_FORMAT || r_phase == PH_HIGH || r_phase == PH_LOW) begin
                if (c == zfr_pkg::CH_ZDLE && !r_esc) begin
                    n_esc = 1'b1;
                end else begin
                    if (r_esc) begin
                        ch    = unesc(c);
                        n_esc = 1'b0;
                    end
                    hx = hexv(ch);
                    if (r_phase == PH_FORMAT) begin
                        if (ch == 8'h42 || ch == 8'h41 || ch == 8'h43) begin
                            n_fmt  = (ch == 8'h42) ? zfr_pkg::FMT_HEX :
                                     (ch == 8'h41) ? zfr_pkg::FMT_B16 : zfr_pkg::FMT_B32;
                            n_hpos = 4'd0;
                            crc_restart = 1'b1;
                            n_phase = PH_HIGH;
                        end else begin
                            n_phase = PH_HUNT;
                            emit    = 1'b1;
                            ev      = zfr_pkg::EV_HDR_BAD;
                        end
                    end else if (r_phase == PH_HIGH && r_fmt == zfr_pkg::FMT_HEX) begin
                        if (hx[4]) begin
                            n_phase = PH_HUNT;
                            emit    = 1'b1;
                            ev      = zfr_pkg::EV_HDR_BAD;
                        end else begin
                            n_nib   = hx[3:0];
                            n_phase = PH_LOW;
                        end
                    end else if (r_phase == PH_LOW && (r_fmt != zfr_pkg::FMT_HEX || hx[4])) begin
                        n_phase = PH_HUNT;
                        emit    = 1'b1;
                        ev      = zfr_pkg::EV_HDR_BAD;
                    end else begin
                        hb_wd  = (r_phase == PH_LOW) ? {r_nib, hx[3:0]} : ch;
                        hb_we  = (r_hpos < 4'd5);
                        feed   = 1'b1;
                        feed_b = hb_wd;
                        n_hpos = r_hpos + 4'd1;
                        if (n_hpos >= 4'd9 ||
                            (r_fmt != zfr_pkg::FMT_B32 && n_hpos >= 4'd7)) begin
                            n_phase = PH_HUNT;
                            emit    = 1'b1;
                            if ((r_fmt == zfr_pkg::FMT_B32) ? (c32 == 32'hdebb20e3)
                                                            : (c16 == 16'h0000)) begin
                                ev     = zfr_pkg::EV_HDR_OK;
                                ev_hdr = 1'b1;
                            end else begin
                                ev = zfr_pkg::EV_HDR_BAD;
                            end
                        end else begin
                            n_phase = (r_phase == PH_LOW) ? PH_HIGH : r_phase;
                        end
                    end
                end
            end else begin
                // frame hunt
                if (c == zfr_pkg::CH_ZPAD) begin
                    n_phase = PH_GOTPAD;
                end else if (c == zfr_pkg::CH_ZDLE) begin
                    if (r_phase == PH_GOTPAD) begin
                        n_oo    = 1'b0;
                        n_phase = PH_FORMAT;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end else if (c == zfr_pkg::CH_O && r_oo) begin
                    if (r_phase == PH_GOTO) begin
                        n_oo    = 1'b0;
                        n_phase = PH_HUNT;
                        emit    = 1'b1;
                        ev      = zfr_pkg::EV_OO;
                    end else begin
                        n_phase = PH_GOTO;
                    end
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_esc    <= 1'b0;
            r_oo     <= 1'b0;
            r_fmt    <= zfr_pkg::FMT_HEX;
            r_hpos   <= 4'd0;
            r_crc16  <= 16'h0000;
            r_crc32  <= 32'hffffffff;
            r_cnt    <= '0;
            r_trail  <= 3'd0;
            r_term   <= 2'd0;
            r_nib    <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_oo    <= n_oo;
            r_fmt   <= n_fmt;
            r_hpos  <= n_hpos;
            r_cnt   <= n_cnt;
            r_trail <= n_trail;
            r_term  <= n_term;
            r_nib   <= n_nib;
            if (crc_restart) begin
                r_crc16 <= 16'h0000;
                r_crc32 <= 32'hffffffff;
            end else if (feed) begin
                r_crc16 <= c16;
                r_crc32 <= c32;
            end
            if (emit)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (hb_we) r_hb[r_hpos[2:0]] <= hb_wd;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_event_kind    <= ev;
            o_header_format <= n_fmt;
            o_payload_value <= ev_pay;
            o_end_kind      <= ev_end;
            o_crc_good      <= ev_crc;
            o_payload_count <= ev_cnt;
            o_frame_type    <= 8'h00;
            o_frame_info    <= 32'h0;
            if (ev_hdr) begin
                // the last stored byte may still be in flight this cycle
                o_frame_type <= r_hb[0];
                o_frame_info <= {(hb_we && r_hpos == 4'd4) ? hb_wd : r_hb[4],
                                 r_hb[3], r_hb[2], r_hb[1]};
            end
        end
    end
endmodule

@@ design/zmodem_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zmodem_frame_receiver_top: framed-byte receiver
// Link filter and cancel detect in front, header/packet parser behind,
// joined by a two-entry request queue.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  input   | in        | i_valid / o_ready   | i_command, i_data_byte
//  output  | out       | o_valid / i_ready   | o_event_kind .. o_payload_count
//
//  One item per cycle sustained while results drain; the queue takes the
//  request at the accepting edge and the parser loads its result register as
//  it pops. The byte-wide CRC update in the parser sets the cycle time.
//  Synchronous active-low reset clears all control state.
//  When the result register stalls, the queue fills and o_ready drops.
// ----------------------------------------------------------------------------
module zmodem_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_frame_type,
    output logic [31:0] o_frame_info,
    output logic [1:0]  o_header_format,
    output logic [7:0]  o_payload_value,
    output logic [1:0]  o_end_kind,
    output logic        o_crc_good,
    output logic [10:0] o_payload_count
);
    logic          push, push_arm, q_nf, q_valid, q_arm, pop;
    zfr_pkg::t_req push_req, q_req;

    zfr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_data_byte(i_data_byte),
        .o_req_valid(push), .o_arm(push_arm), .o_req(push_req),
        .i_q_ready(q_nf)
    );

    zfr_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_push_arm(push_arm), .i_push_req(push_req),
        .o_not_full(q_nf), .o_valid(q_valid), .o_arm(q_arm), .o_req(q_req),
        .i_pop(pop)
    );

    zfr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .i_arm(q_arm), .i_req(q_req), .o_pop(pop),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_event_kind(o_event_kind), .o_frame_type(o_frame_type),
        .o_frame_info(o_frame_info), .o_header_format(o_header_format),
        .o_payload_value(o_payload_value), .o_end_kind(o_end_kind),
        .o_crc_good(o_crc_good), .o_payload_count(o_payload_count)
    );

`ifndef SYNTHESIS
    // a stalled result must keep its event code
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_event_kind))
        else $error("result changed while stalled");

    // queue never pushed while full
    a_nofull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> q_nf)
        else $error("push into full queue");

    // pop only with data present
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
`endif
endmodule
